// ===== hw/rtl/ray_axis_rect_intersect_core_macros.svh =====
// assertion macros for the ray/rectangle intersection core
// used by the top level only
`ifndef RAY_AXIS_RECT_INTERSECT_CORE_MACROS_SVH
`define RAY_AXIS_RECT_INTERSECT_CORE_MACROS_SVH
// implication checked at every edge outside reset
`define RARI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define RARI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/rari_pkg.sv =====
// types and constants for the ray/rectangle intersection core
// no dependencies
`timescale 1ns / 1ps
package rari_pkg;
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] t_lower;
    logic signed [31:0] t_upper;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] hit_t;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic              normal_negative;
    logic [7:0]        hit_material;
  } out_word_t;

  localparam logic [1:0] AXIS_XY = 2'd0;
  localparam logic [1:0] AXIS_XZ = 2'd1;
  localparam logic [1:0] AXIS_YZ = 2'd2;

  localparam logic [2:0] REG_AXIS = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam logic [2:0] REG_AMIN = 3'd2;
  localparam logic [2:0] REG_AMAX = 3'd3;
  localparam logic [2:0] REG_BMIN = 3'd4;
  localparam logic [2:0] REG_BMAX = 3'd5;
  localparam logic [2:0] REG_FLIP = 3'd6;
  localparam logic [2:0] REG_MAT = 3'd7;

  // classified ray handed from front to back
  typedef struct packed {
    logic              valid;
    logic              ok;
    logic signed [31:0] org_a;
    logic signed [31:0] org_b;
    logic signed [31:0] dir_a;
    logic signed [31:0] dir_b;
    logic signed [31:0] t_lower;
    logic signed [31:0] t_upper;
    logic [1:0]        axis;
    logic signed [31:0] org_n;
    logic signed [31:0] dir_n;
  } cls_t;
endpackage

// ===== hw/rtl/rari_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on nothing
`timescale 1ns / 1ps
module rari_div #(
  parameter int NW = 50,
  parameter int DW = 32,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic          in_neg,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic          out_neg,
  output logic [TW-1:0] out_tag
);
  // stage k resolves quotient bit NW-1-k
  logic          v_r [NW];
  logic [NW-1:0] q_r [NW];
  logic [DW:0]   rem_r [NW];
  logic [DW-1:0] den_r [NW];
  logic          neg_r [NW];
  logic [TW-1:0] tag_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic          v_i;
    logic [NW-1:0] q_i;
    logic [DW:0]   rem_i;
    logic [DW-1:0] den_i;
    logic          neg_i;
    logic [TW-1:0] tag_i;
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    if (k == 0) begin : g_first
      assign v_i = in_valid;
      assign q_i = in_num;
      assign rem_i = '0;
      assign den_i = in_den;
      assign neg_i = in_neg;
      assign tag_i = in_tag;
    end else begin : g_next
      assign v_i = v_r[k-1];
      assign q_i = q_r[k-1];
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign neg_i = neg_r[k-1];
      assign tag_i = tag_r[k-1];
    end
    assign sh = {rem_i, q_i[NW-1]};
    assign df = sh - {2'b00, den_i};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_i;
      end
      den_r[k] <= den_i;
      neg_r[k] <= neg_i;
      tag_r[k] <= tag_i;
      if (!df[DW+1]) begin
        rem_r[k] <= df[DW:0];
        q_r[k] <= {q_i[NW-2:0], 1'b1};
      end else begin
        rem_r[k] <= sh[DW:0];
        q_r[k] <= {q_i[NW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quo = q_r[NW-1];
  assign out_neg = neg_r[NW-1];
  assign out_tag = tag_r[NW-1];
endmodule

// ===== hw/rtl/rari_front.sv =====
// front: picks axes, checks direction, forms the division operands
// depends on rari_pkg
`timescale 1ns / 1ps
module rari_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rari_pkg::in_word_t in_word,
  input  logic [1:0]        axis,
  input  logic signed [31:0] offset,
  output rari_pkg::cls_t    cls,
  output logic [32+FRAC_BITS:0] num_mag,
  output logic [31:0]       den_mag,
  output logic              q_neg
);
  import rari_pkg::*;
  localparam int NW = 33 + FRAC_BITS;

  cls_t c_nxt, c_r;
  logic signed [32:0] diff;
  logic signed [31:0] dn;
  logic signed [NW:0] numw;
  logic [NW-1:0] nm_nxt, nm_r;
  logic [31:0] dm_nxt, dm_r;
  logic qn_nxt, qn_r;

  always_comb begin
    c_nxt = '0;
    c_nxt.valid = in_valid;
    c_nxt.axis = axis;
    c_nxt.t_lower = in_word.t_lower;
    c_nxt.t_upper = in_word.t_upper;
    dn = in_word.dir_z;
    c_nxt.ok = 1'b1;
    unique case (axis)
      AXIS_XY: begin
        dn = in_word.dir_z; c_nxt.org_n = in_word.origin_z;
        c_nxt.org_a = in_word.origin_x; c_nxt.dir_a = in_word.dir_x;
        c_nxt.org_b = in_word.origin_y; c_nxt.dir_b = in_word.dir_y;
      end
      AXIS_XZ: begin
        dn = in_word.dir_y; c_nxt.org_n = in_word.origin_y;
        c_nxt.org_a = in_word.origin_x; c_nxt.dir_a = in_word.dir_x;
        c_nxt.org_b = in_word.origin_z; c_nxt.dir_b = in_word.dir_z;
      end
      AXIS_YZ: begin
        dn = in_word.dir_x; c_nxt.org_n = in_word.origin_x;
        c_nxt.org_a = in_word.origin_y; c_nxt.dir_a = in_word.dir_y;
        c_nxt.org_b = in_word.origin_z; c_nxt.dir_b = in_word.dir_z;
      end
      default: c_nxt.ok = 1'b0;
    endcase
    c_nxt.dir_n = dn;
    if (dn == '0) c_nxt.ok = 1'b0;
    diff = 33'(offset) - 33'(c_nxt.org_n);
    numw = (NW+1)'(diff) <<< FRAC_BITS;
    nm_nxt = diff[32] ? NW'(-numw) : NW'(numw);
    dm_nxt = dn[31] ? 32'(-dn) : 32'(dn);
    qn_nxt = diff[32] ^ dn[31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else begin
      c_r.valid <= c_nxt.valid;
    end
    c_r.ok <= c_nxt.ok;
    c_r.org_a <= c_nxt.org_a;
    c_r.org_b <= c_nxt.org_b;
    c_r.dir_a <= c_nxt.dir_a;
    c_r.dir_b <= c_nxt.dir_b;
    c_r.t_lower <= c_nxt.t_lower;
    c_r.t_upper <= c_nxt.t_upper;
    c_r.axis <= c_nxt.axis;
    c_r.org_n <= c_nxt.org_n;
    c_r.dir_n <= c_nxt.dir_n;
    nm_r <= nm_nxt;
    dm_r <= dm_nxt;
    qn_r <= qn_nxt;
  end

  assign cls = c_r;
  assign num_mag = nm_r;
  assign den_mag = dm_r;
  assign q_neg = qn_r;
endmodule

// ===== hw/rtl/rari_queue.sv =====
// fixed-latency delay line carrying the classified ray past the divider
// depends on rari_pkg
`timescale 1ns / 1ps
module rari_queue #(
  parameter int DEPTH = 50
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rari_pkg::cls_t in_cls,
  output rari_pkg::cls_t out_cls
);
  import rari_pkg::*;
  cls_t q_r [DEPTH];
  for (genvar k = 0; k < DEPTH; k++) begin : g_q
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q_r[k].valid <= 1'b0;
      end else begin
        q_r[k].valid <= (k == 0) ? in_cls.valid : q_r[k == 0 ? 0 : k-1].valid;
      end
      if (k == 0) begin
        q_r[k][$bits(cls_t)-2:0] <= in_cls[$bits(cls_t)-2:0];
      end else begin
        q_r[k][$bits(cls_t)-2:0] <= q_r[k == 0 ? 0 : k-1][$bits(cls_t)-2:0];
      end
    end
  end
  assign out_cls = q_r[DEPTH-1];
endmodule

// ===== hw/rtl/rari_back.sv =====
// back: interval test, hit point multiply, bound test, result register
// depends on rari_pkg
`timescale 1ns / 1ps
module rari_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rari_pkg::cls_t    cls,
  input  logic [32+FRAC_BITS:0] quo,
  input  logic              q_neg,
  input  logic signed [31:0] a_min,
  input  logic signed [31:0] a_max,
  input  logic signed [31:0] b_min,
  input  logic signed [31:0] b_max,
  input  logic              flip,
  input  logic [7:0]        material,
  output logic              out_strobe,
  output rari_pkg::out_word_t out_word
);
  import rari_pkg::*;
  localparam int NW = 33 + FRAC_BITS;

  // stage 1: sign, interval
  logic signed [NW:0] ts;
  logic in_int;
  logic s1_v_r, s1_ok_r;
  logic signed [31:0] s1_t_r;
  cls_t s1_c_r;
  always_comb begin
    ts = q_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    in_int = (ts >= (NW+1)'(cls.t_lower)) && (ts <= (NW+1)'(cls.t_upper));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= cls.valid;
    end
    s1_ok_r <= cls.ok && in_int;
    s1_t_r <= ts[31:0];
    s1_c_r <= cls;
  end

  // stage 2: products
  logic s2_v_r, s2_ok_r;
  logic signed [63:0] pa_r, pb_r, pn_r;
  logic signed [31:0] s2_t_r;
  cls_t s2_c_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_ok_r <= s1_ok_r;
    pa_r <= s1_t_r * s1_c_r.dir_a;
    pb_r <= s1_t_r * s1_c_r.dir_b;
    pn_r <= s1_t_r * s1_c_r.dir_n;
    s2_t_r <= s1_t_r;
    s2_c_r <= s1_c_r;
  end

  // stage 3: coordinates, bounds, saturation (arithmetic shift is floor)
  logic signed [64:0] ca, cb, cn;
  logic signed [31:0] sa, sb, pn;
  logic in_b;
  out_word_t o_nxt, o_r;
  logic v_r;

  function automatic logic signed [31:0] sat(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7fffffff;
    if (v < -65'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_comb begin
    ca = 65'(s2_c_r.org_a) + 65'(pa_r >>> FRAC_BITS);
    cb = 65'(s2_c_r.org_b) + 65'(pb_r >>> FRAC_BITS);
    // truncated t can leave the normal coordinate a step off the plane
    cn = 65'(s2_c_r.org_n) + 65'(pn_r >>> FRAC_BITS);
    in_b = (ca >= 65'(a_min)) && (ca <= 65'(a_max)) &&
           (cb >= 65'(b_min)) && (cb <= 65'(b_max));
    sa = sat(ca);
    sb = sat(cb);
    pn = sat(cn);
    o_nxt = '0;
    if (s2_ok_r && in_b) begin
      o_nxt.hit = 1'b1;
      o_nxt.hit_t = s2_t_r;
      o_nxt.normal_negative = flip;
      o_nxt.hit_material = material;
      unique case (s2_c_r.axis)
        AXIS_XY: begin o_nxt.point_x = sa; o_nxt.point_y = sb; o_nxt.point_z = pn; end
        AXIS_XZ: begin o_nxt.point_x = sa; o_nxt.point_y = pn; o_nxt.point_z = sb; end
        default: begin o_nxt.point_x = pn; o_nxt.point_y = sa; o_nxt.point_z = sb; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= s2_v_r;
    end
    o_r <= o_nxt;
  end

  assign out_strobe = v_r;
  assign out_word = o_r;
endmodule

// ===== hw/rtl/ray_axis_rect_intersect_core.sv =====
// top level of the ray/rectangle intersection core
// depends on rari_pkg, rari_front, rari_div, rari_queue, rari_back and the macro header
`timescale 1ns / 1ps
`include "ray_axis_rect_intersect_core_macros.svh"
// Takes one ray every cycle (busy is always low) and returns one word per ray on
// out_strobe after it passes one front stage, FRAC_BITS+33 divider stages (one
// quotient bit each) and three back stages. The receiver cannot stall, so every
// strobe must be taken. Registers are to be written by the user only while no ray
// is in flight; the block itself does not enforce this.
module ray_axis_rect_intersect_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rari_pkg::in_word_t in_word,
  output logic               out_strobe,
  output rari_pkg::out_word_t out_word,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import rari_pkg::*;
  localparam int NW = 33 + FRAC_BITS;

  logic [1:0] axis_r;
  logic signed [31:0] off_r, amin_r, amax_r, bmin_r, bmax_r;
  logic flip_r;
  logic [7:0] mat_r;
  logic [2:0] ridx;
  logic wr;

  assign ridx = cfg_paddr[4:2];
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= '0; off_r <= '0; amin_r <= '0; amax_r <= '0;
      bmin_r <= '0; bmax_r <= '0; flip_r <= 1'b0; mat_r <= '0;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      unique case (ridx)
        REG_AXIS:   axis_r <= cfg_pwdata[1:0];
        REG_OFFSET: off_r <= cfg_pwdata;
        REG_AMIN:   amin_r <= cfg_pwdata;
        REG_AMAX:   amax_r <= cfg_pwdata;
        REG_BMIN:   bmin_r <= cfg_pwdata;
        REG_BMAX:   bmax_r <= cfg_pwdata;
        REG_FLIP:   flip_r <= cfg_pwdata[0];
        REG_MAT:    mat_r <= cfg_pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (ridx)
      REG_AXIS:   cfg_prdata = {30'd0, axis_r};
      REG_OFFSET: cfg_prdata = off_r;
      REG_AMIN:   cfg_prdata = amin_r;
      REG_AMAX:   cfg_prdata = amax_r;
      REG_BMIN:   cfg_prdata = bmin_r;
      REG_BMAX:   cfg_prdata = bmax_r;
      REG_FLIP:   cfg_prdata = {31'd0, flip_r};
      REG_MAT:    cfg_prdata = {24'd0, mat_r};
    endcase
  end

  cls_t f_cls, q_cls;
  logic [NW-1:0] f_num, d_quo;
  logic [31:0] f_den;
  logic f_neg, d_neg, d_v;
  logic d_tag;

  rari_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start && !busy), .in_word(in_word),
    .axis(axis_r), .offset(off_r), .cls(f_cls), .num_mag(f_num),
    .den_mag(f_den), .q_neg(f_neg)
  );

  rari_div #(.NW(NW), .DW(32), .TW(1)) u_div (
    .clk(clk), .rst_n(rst_n), .in_valid(f_cls.valid), .in_num(f_num),
    .in_den(f_den), .in_neg(f_neg), .in_tag(f_cls.ok), .out_valid(d_v),
    .out_quo(d_quo), .out_neg(d_neg), .out_tag(d_tag)
  );

  rari_queue #(.DEPTH(NW)) u_queue (
    .clk(clk), .rst_n(rst_n), .in_cls(f_cls), .out_cls(q_cls)
  );

  rari_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cls(q_cls), .quo(d_quo), .q_neg(d_neg),
    .a_min(amin_r), .a_max(amax_r), .b_min(bmin_r),
    .b_max(bmax_r), .flip(flip_r), .material(mat_r),
    .out_strobe(out_strobe), .out_word(out_word)
  );

  `RARI_ASSERT_IMP(a_div_align, d_v, q_cls.valid && d_tag == q_cls.ok)
  `RARI_ASSERT_IMP(a_queue_align, q_cls.valid, d_v)
  `RARI_ASSERT_IMP(a_miss_zero, out_strobe && !out_word.hit, out_word == '0)
  `RARI_ASSERT_IMP(a_hit_mat, out_strobe && out_word.hit, out_word.hit_material == mat_r)
endmodule
